/* rtl/bba_pkg.sv */
// Shared types, constants and helpers for the bitmap block allocator.
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_WIDTH = 32;
	localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int BLOCK_W    = $clog2(MAX_BLOCKS);
	localparam int TOTAL_W    = BLOCK_W + 1;
	localparam int WORD_IDX_W = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W  = $clog2(WORD_WIDTH);
	localparam int WHI_W      = TOTAL_W - BIT_IDX_W;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_DOUBLE = 2'd2,
		STAT_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_CHK,
		ST_RESP
	} state_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_IDX_W-1:0] idx;
	} free_bit_t;

	// Lowest clear bit of a word among the bits enabled by mask.
	function automatic free_bit_t first_free(input logic [WORD_WIDTH-1:0] word,
		input logic [WORD_WIDTH-1:0] mask);
		free_bit_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
			if (mask[i] && !word[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
//
// channel   dir  signals                      contents
// s_*       in   s_tvalid s_tready            request transfer
//                s_tdata[15:0]                block_number[11:0], zero pad
//                s_tuser[0]                   action (0 allocate, 1 free)
// m_*       out  m_tvalid m_tready            response transfer
//                m_tdata[15:0]                status[1:0], allocated_block[13:2], pad
// cfg_*     in   cfg_we cfg_wdata[12:0]       total_blocks write
//
// An allocate scans from word 0 and reads 1 to 128 bitmap words:
// the scan reads one 32-bit word per cycle through the single read port.
// A free reads the word, then checks and clears the bit; out of range it skips both.
// The request side is not ready while an item is in progress; one finished
// response may wait in the output register while the next request is taken.
// Reset clears per-word valid bits, so there is no clearing pass.
module bitmap_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // block_number[11:0]
	input  logic [0:0]                  s_tuser,  // action[0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // status[1:0], allocated_block[13:2]
	input  logic                        cfg_we,
	input  logic [bba_pkg::TOTAL_W-1:0] cfg_wdata
);

	bba_pkg::state_t state_q, state_d;

	logic [bba_pkg::TOTAL_W-1:0]    limit_q;
	logic [bba_pkg::WORD_IDX_W-1:0] word_q;
	logic [bba_pkg::BLOCK_W-1:0]    blk_q;
	logic [bba_pkg::MAP_WORDS-1:0]  row_valid_q;
	logic                           rd_hit_q;
	bba_pkg::status_t               res_status_q;
	logic [bba_pkg::BLOCK_W-1:0]    res_block_q;
	logic                           m_tvalid_q;
	logic [15:0]                    m_tdata_q;

	logic                           accept;
	bba_pkg::action_t               req_action;
	logic [bba_pkg::BLOCK_W-1:0]    req_block;
	logic                           req_range;

	logic                           rd_en;
	logic [bba_pkg::WORD_IDX_W-1:0] rd_addr;
	logic [bba_pkg::WORD_WIDTH-1:0] rd_data;
	logic [bba_pkg::WORD_WIDTH-1:0] word_data;
	logic                           wr_en;
	logic [bba_pkg::WORD_IDX_W-1:0] wr_addr;
	logic [bba_pkg::WORD_WIDTH-1:0] wr_data;

	logic [bba_pkg::WHI_W-1:0]      limit_hi;
	logic [bba_pkg::BIT_IDX_W-1:0]  limit_lo;
	logic [bba_pkg::WHI_W-1:0]      word_ext;
	logic [bba_pkg::WORD_WIDTH-1:0] scan_mask;
	bba_pkg::free_bit_t             scan_res;
	logic [bba_pkg::TOTAL_W-1:0]    next_base;
	logic                           scan_last;
	logic                           free_bit;
	logic                           out_free;

	logic                           res_load;
	bba_pkg::status_t               res_status_d;
	logic [bba_pkg::BLOCK_W-1:0]    res_block_d;

	assign req_action = bba_pkg::action_t'(s_tuser[0]);
	assign req_block  = s_tdata[bba_pkg::BLOCK_W-1:0];
	assign accept     = s_tvalid && s_tready;
	assign req_range  = {1'b0, req_block} >= limit_q;
	assign out_free   = !m_tvalid_q || m_tready;

	// Words never written read as zero.
	assign word_data = rd_hit_q ? rd_data : '0;

	assign limit_hi  = limit_q[bba_pkg::TOTAL_W-1:bba_pkg::BIT_IDX_W];
	assign limit_lo  = limit_q[bba_pkg::BIT_IDX_W-1:0];
	assign word_ext  = bba_pkg::WHI_W'(word_q);
	assign next_base = {word_ext + 1'b1, bba_pkg::BIT_IDX_W'(0)};
	assign scan_last = next_base >= limit_q;
	assign free_bit  = word_data[blk_q[bba_pkg::BIT_IDX_W-1:0]];
	assign scan_res  = bba_pkg::first_free(word_data, scan_mask);

	always_comb begin
		if (word_ext < limit_hi) begin
			scan_mask = '1;
		end else if (word_ext == limit_hi) begin
			scan_mask = (bba_pkg::WORD_WIDTH'(1) << limit_lo) - 1'b1;
		end else begin
			scan_mask = '0;
		end
	end

	bba_ram #(
		.WIDTH(bba_pkg::WORD_WIDTH),
		.DEPTH(bba_pkg::MAP_WORDS)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_action == bba_pkg::ACT_ALLOC) begin
						state_d = bba_pkg::ST_SCAN;
					end else if (req_range) begin
						state_d = bba_pkg::ST_RESP;
					end else begin
						state_d = bba_pkg::ST_FREE_CHK;
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				if (scan_res.found || scan_last) begin
					state_d = bba_pkg::ST_RESP;
				end
			end
			bba_pkg::ST_FREE_CHK: state_d = bba_pkg::ST_RESP;
			bba_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready     = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = word_q;
		wr_en        = 1'b0;
		wr_addr      = word_q;
		wr_data      = word_data;
		res_load     = 1'b0;
		res_status_d = bba_pkg::STAT_OK;
		res_block_d  = '0;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (req_action == bba_pkg::ACT_ALLOC) begin
						rd_en   = 1'b1;
						rd_addr = '0;
					end else if (req_range) begin
						res_load     = 1'b1;
						res_status_d = bba_pkg::STAT_RANGE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = req_block[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				if (scan_res.found) begin
					wr_en        = 1'b1;
					wr_data      = word_data | (bba_pkg::WORD_WIDTH'(1) << scan_res.idx);
					res_load     = 1'b1;
					res_status_d = bba_pkg::STAT_OK;
					res_block_d  = {word_q, scan_res.idx};
				end else if (scan_last) begin
					res_load     = 1'b1;
					res_status_d = bba_pkg::STAT_FULL;
				end else begin
					// prefetch the next word while this one is checked
					rd_en   = 1'b1;
					rd_addr = word_q + 1'b1;
				end
			end
			bba_pkg::ST_FREE_CHK: begin
				wr_addr  = blk_q[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
				res_load = 1'b1;
				if (free_bit) begin
					wr_en        = 1'b1;
					wr_data      = word_data &
						~(bba_pkg::WORD_WIDTH'(1) << blk_q[bba_pkg::BIT_IDX_W-1:0]);
					res_status_d = bba_pkg::STAT_OK;
				end else begin
					res_status_d = bba_pkg::STAT_DOUBLE;
				end
			end
			bba_pkg::ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::ST_IDLE;
			limit_q     <= bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS);
			row_valid_q <= '0;
			rd_hit_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			word_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// saturate the total to the bitmap size
				limit_q <= (cfg_wdata > bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS)) ?
					bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS) : cfg_wdata;
			end
			if (rd_en) begin
				rd_hit_q <= row_valid_q[rd_addr];
				word_q   <= rd_addr;
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (state_q == bba_pkg::ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= req_block;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_block_q  <= res_block_d;
		end
		if (state_q == bba_pkg::ST_RESP && out_free) begin
			m_tdata_q <= {2'b00, res_block_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A scan never reads past the word holding the last managed block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::ST_SCAN) |->
			({word_ext, bba_pkg::BIT_IDX_W'(0)} < limit_q || word_q == '0))
		else $error("scan beyond managed range");

	// A granted block lies below the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::ST_SCAN && res_load && res_status_d == bba_pkg::STAT_OK) |->
			({1'b0, res_block_d} < limit_q))
		else $error("granted block out of range");

	// An accepted allocate starts a scan on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_action == bba_pkg::ACT_ALLOC) |=> (state_q == bba_pkg::ST_SCAN))
		else $error("allocate did not start a scan");

endmodule
